// ===== hdl/spp_pkg.sv =====
package spp_pkg;

    localparam int NUMBER_BITS = 63;
    localparam int CNT_W       = $clog2(NUMBER_BITS);

    typedef logic [NUMBER_BITS-1:0] t_num;
    typedef logic [CNT_W-1:0]       t_cnt;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPLIT,
        S_POW,
        S_POW_MUL,
        S_POW_SQR,
        S_SQR,
        S_SQR_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start;
        t_num a;
        t_num b;
    } t_mul_req;

    typedef struct packed {
        logic done;
        t_num product;
    } t_mul_rsp;

endpackage

// ===== hdl/spp_if.sv =====
interface spp_cand_if import spp_pkg::*; ();
    logic valid;
    logic ready;
    t_num candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

interface spp_res_if import spp_pkg::*; ();
    logic valid;
    logic ready;
    logic probable_prime;

    modport source (output valid, output probable_prime, input ready);
    modport sink   (input valid, input probable_prime, output ready);
endinterface

// ===== hdl/spp_mulmod.sv =====
module spp_mulmod import spp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    input  t_num     i_mod,
    output t_mul_rsp o_rsp
);

    localparam t_cnt LAST_STEP = t_cnt'(NUMBER_BITS - 1);

    logic r_busy;
    logic r_done;
    t_cnt r_cnt;
    t_num r_a;
    t_num r_b;
    t_num r_acc;

    logic n_busy;
    logic n_done;
    t_cnt n_cnt;
    t_num n_a;
    t_num n_b;
    t_num n_acc;

    // Both operands are below the modulus, so one conditional subtract reduces the sum.
    function automatic t_num add_mod(input t_num x, input t_num y, input t_num m);
        logic [NUMBER_BITS:0] sum;
        logic [NUMBER_BITS:0] m_ext;
        sum   = {1'b0, x} + {1'b0, y};
        m_ext = {1'b0, m};
        if (sum >= m_ext) begin
            sum = sum - m_ext;
        end
        return sum[NUMBER_BITS-1:0];
    endfunction

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        if (r_busy) begin
            if (r_b[0]) begin
                n_acc = add_mod(r_acc, r_a, i_mod);
            end
            n_a   = add_mod(r_a, r_a, i_mod);
            n_b   = r_b >> 1;
            n_cnt = r_cnt + t_cnt'(1);
            if (r_cnt == LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_a    = i_req.a;
            n_b    = i_req.b;
            n_acc  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc;

endmodule

// ===== hdl/strong_probable_prime_base2.sv =====
// Values below 4 and even values go from the accepting edge straight to the result beat; odd
// values first split n-1 into d * 2^r with d odd, then run a square-and-multiply of 2^d mod n
// on the shift-add-reduce multiplier, then up to r-1 squarings of the result.
// Candidates: one at a time; a new one is taken only after the result beat is accepted.
// Reset: synchronous, active low; the sequencer returns to idle and any pending result is dropped.
module strong_probable_prime_base2 import spp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    spp_cand_if.sink     i_cand,
    spp_res_if.source    o_result
);

    t_state r_state;
    t_state n_state;

    t_num r_n;
    t_num r_d;
    t_num r_x;
    t_num r_base;
    t_cnt r_r;
    logic r_result;

    t_num n_n;
    t_num n_d;
    t_num n_x;
    t_num n_base;
    t_cnt n_r;
    logic n_result;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;
    t_num     n_minus_one;
    logic     cand_accept;
    logic     cand_small;
    logic     cand_two_three;

    localparam t_num NUM_ONE = t_num'(1);
    localparam t_num NUM_TWO = t_num'(2);

    spp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .i_mod   (r_n),
        .o_rsp   (mul_rsp)
    );

    assign n_minus_one    = r_n - NUM_ONE;
    assign cand_accept    = i_cand.valid && i_cand.ready;
    assign cand_small     = (i_cand.candidate[NUMBER_BITS-1:2] == '0);
    assign cand_two_three = cand_small && i_cand.candidate[1];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (cand_accept) begin
                    if (cand_small || !i_cand.candidate[0]) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SPLIT;
                    end
                end
            end
            S_SPLIT: begin
                if (r_d[0]) begin
                    n_state = S_POW;
                end
            end
            S_POW: begin
                if (r_d == '0) begin
                    if (r_x == NUM_ONE || r_x == n_minus_one) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SQR;
                    end
                end else if (r_d[0]) begin
                    n_state = S_POW_MUL;
                end else begin
                    n_state = S_POW_SQR;
                end
            end
            S_POW_MUL: begin
                if (mul_rsp.done) begin
                    n_state = S_POW_SQR;
                end
            end
            S_POW_SQR: begin
                if (mul_rsp.done) begin
                    n_state = S_POW;
                end
            end
            S_SQR: begin
                if (r_r > t_cnt'(1)) begin
                    n_state = S_SQR_WAIT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SQR_WAIT: begin
                if (mul_rsp.done) begin
                    if (mul_rsp.product == n_minus_one) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SQR;
                    end
                end
            end
            S_DONE: begin
                if (o_result.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs: handshake and multiplier requests.
    always_comb begin
        i_cand.ready   = 1'b0;
        o_result.valid = 1'b0;
        mul_req.start  = 1'b0;
        mul_req.a      = r_x;
        mul_req.b      = r_base;
        unique case (r_state)
            S_IDLE: i_cand.ready = 1'b1;
            S_POW: begin
                if (r_d != '0) begin
                    mul_req.start = 1'b1;
                    if (!r_d[0]) begin
                        mul_req.a = r_base;
                    end
                end
            end
            S_POW_MUL: begin
                // The base squaring starts in the cycle the first product lands.
                mul_req.start = mul_rsp.done;
                mul_req.a     = r_base;
            end
            S_SQR: begin
                mul_req.start = (r_r > t_cnt'(1));
                mul_req.b     = r_x;
            end
            S_DONE: o_result.valid = 1'b1;
            default: ;
        endcase
    end

    // Datapath registers.
    always_comb begin
        n_n      = r_n;
        n_d      = r_d;
        n_x      = r_x;
        n_base   = r_base;
        n_r      = r_r;
        n_result = r_result;
        case (r_state)
            S_IDLE: begin
                n_n      = i_cand.candidate;
                n_d      = i_cand.candidate - NUM_ONE;
                n_r      = '0;
                n_x      = NUM_ONE;
                n_base   = NUM_TWO;
                n_result = cand_two_three;
            end
            S_SPLIT: begin
                if (!r_d[0]) begin
                    n_d = r_d >> 1;
                    n_r = r_r + t_cnt'(1);
                end
            end
            S_POW: begin
                n_result = (r_d == '0) && (r_x == NUM_ONE || r_x == n_minus_one);
            end
            S_POW_MUL: begin
                if (mul_rsp.done) begin
                    n_x = mul_rsp.product;
                end
            end
            S_POW_SQR: begin
                if (mul_rsp.done) begin
                    n_base = mul_rsp.product;
                    n_d    = r_d >> 1;
                end
            end
            S_SQR_WAIT: begin
                if (mul_rsp.done) begin
                    n_x      = mul_rsp.product;
                    n_r      = r_r - t_cnt'(1);
                    n_result = (mul_rsp.product == n_minus_one);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_n      <= n_n;
        r_d      <= n_d;
        r_x      <= n_x;
        r_base   <= n_base;
        r_r      <= n_r;
        r_result <= n_result;
    end

    assign o_result.probable_prime = r_result;

endmodule

// ===== hdl/spp_chk.sv =====
module spp_chk import spp_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_cand_valid,
    input logic i_cand_ready,
    input t_num i_cand_candidate,
    input logic i_res_valid,
    input logic i_res_ready,
    input logic i_res_prime
);

    logic cand_beat;
    assign cand_beat = i_cand_valid && i_cand_ready;

    // A pending result holds until it is taken.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_prime))
        else $error("result beat dropped or changed while stalled");

    // One candidate at a time: no new beat right after one is taken.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cand_beat |=> !i_cand_ready)
        else $error("candidate accepted while previous one still in work");

    a_no_ready_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !i_cand_ready)
        else $error("input ready while a result is pending");

    // Even values from four up are rejected without touching the multiplier.
    a_even_fast_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cand_beat && !i_cand_candidate[0] && (i_cand_candidate[NUMBER_BITS-1:2] != '0)
        |=> i_res_valid && !i_res_prime)
        else $error("even candidate not rejected in the next cycle");

endmodule

bind strong_probable_prime_base2 spp_chk u_spp_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_cand_valid     (i_cand.valid),
    .i_cand_ready     (i_cand.ready),
    .i_cand_candidate (i_cand.candidate),
    .i_res_valid      (o_result.valid),
    .i_res_ready      (o_result.ready),
    .i_res_prime      (o_result.probable_prime)
);
